FILE: rtl/mdf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Decision filter package
// Shared sizes, mode codes and reset values for the multichannel decision filter.
// ----------------------------------------------------------------------------
package mdf_pkg;

    // Window geometry.
    localparam int CHANNELS   = 4;
    localparam int WINDOW_LEN = 8;
    localparam int DEPTH      = CHANNELS * WINDOW_LEN;
    localparam int ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PTR_W      = $clog2(WINDOW_LEN);
    localparam int SLOT_W     = $clog2(WINDOW_LEN + 1);
    localparam int CNT_W      = $clog2(WINDOW_LEN + 1);

    // Arithmetic widths: full-width window sum, divisor, smooth-hold limit.
    localparam int SUM_W      = 32 + $clog2(WINDOW_LEN) + 1;
    localparam int DIV_W      = $clog2(WINDOW_LEN + 1);
    localparam int LIM_W      = 50;

    // Configuration reset value.
    localparam logic [15:0] THRESH_RESET = 16'd6554;

    // Decision modes.
    localparam logic [2:0] MODE_TRIM   = 3'd0;
    localparam logic [2:0] MODE_MODE   = 3'd1;
    localparam logic [2:0] MODE_MEDIAN = 3'd2;
    localparam logic [2:0] MODE_SMOOTH = 3'd3;
    localparam logic [2:0] MODE_MAX    = 3'd4;
    localparam logic [2:0] MODE_MIN    = 3'd5;

endpackage

FILE: rtl/mdf_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Decision filter channels
// Valid/ready interfaces for the sample input and the decision output.
// ----------------------------------------------------------------------------
interface mdf_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] sample_value;
    logic        [1:0]  channel;
    logic        [2:0]  filter_mode;

    modport source (output valid, sample_value, channel, filter_mode, input ready);
    modport sink   (input valid, sample_value, channel, filter_mode, output ready);
endinterface

interface mdf_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] decided_value;

    modport source (output valid, decided_value, input ready);
    modport sink   (input valid, decided_value, output ready);
endinterface

FILE: rtl/mdf_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module mdf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic                                  i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Storage write and registered read.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

FILE: rtl/mdf_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Constant divider
// Divides an unsigned magnitude by WINDOW_LEN-2 or by WINDOW_LEN through one
// shared reciprocal multiplier, upper half first and lower half second.
// ----------------------------------------------------------------------------
module mdf_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic                       i_trim,
    input  logic [mdf_pkg::SUM_W-1:0]  i_dividend,
    output logic                       o_busy,
    output logic                       o_done,
    output logic [mdf_pkg::SUM_W-1:0]  o_quotient
);
    localparam int SUM_W  = mdf_pkg::SUM_W;
    localparam int CH     = SUM_W / 2;
    localparam int RW     = 6;
    localparam int W      = CH + RW;
    localparam int KW     = W + 2;
    localparam int D_TRIM = mdf_pkg::WINDOW_LEN - 2;
    localparam int D_FULL = mdf_pkg::WINDOW_LEN;
    localparam int S_TRIM = W + $clog2(D_TRIM);
    localparam int S_FULL = W + $clog2(D_FULL);
    localparam logic [KW-1:0] K_TRIM =
        KW'(((64'd1 << S_TRIM) + 64'(D_TRIM) - 64'd1) / 64'(D_TRIM));
    localparam logic [KW-1:0] K_FULL =
        KW'(((64'd1 << S_FULL) + 64'(D_FULL) - 64'd1) / 64'(D_FULL));

    logic              r_busy;
    logic              r_done;
    logic              r_phase;
    logic              r_trim;
    logic [SUM_W-1:0]  r_x;
    logic [W-1:0]      r_qhi;
    logic [RW-1:0]     r_rem;
    logic [SUM_W-1:0]  r_q;
    logic [W-1:0]      w_v;
    logic [KW-1:0]     w_k;
    logic [W+KW-1:0]   w_prod;
    logic [W-1:0]      w_q;
    logic [W-1:0]      w_qd;
    logic [RW-1:0]     w_r;

    // Operand of the shared multiplier: the upper half first, then the
    // remainder of the upper half joined with the lower half.
    assign w_v = r_phase ? {r_rem, r_x[CH-1:0]} : W'(r_x[SUM_W-1:CH]);
    assign w_k = r_trim ? K_TRIM : K_FULL;

    // Reciprocal multiplication gives the exact floor quotient of the operand.
    assign w_prod = w_v * w_k;
    assign w_q    = r_trim ? W'(w_prod >> S_TRIM) : W'(w_prod >> S_FULL);
    assign w_qd   = r_trim ? W'(w_q * W'(D_TRIM)) : W'(w_q * W'(D_FULL));
    assign w_r    = RW'(w_v - w_qd);

    // Two-step sequence: upper quotient and remainder, then the full quotient.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_phase <= 1'b0;
        end else begin
            r_done <= r_busy && r_phase;
            if (i_start && !r_busy) begin
                r_busy  <= 1'b1;
                r_phase <= 1'b0;
                r_trim  <= i_trim;
                r_x     <= i_dividend;
            end else if (r_busy) begin
                if (!r_phase) begin
                    r_qhi   <= w_q;
                    r_rem   <= w_r;
                    r_phase <= 1'b1;
                end else begin
                    r_q     <= (SUM_W'(r_qhi) << CH) + SUM_W'(w_q);
                    r_busy  <= 1'b0;
                    r_phase <= 1'b0;
                end
            end
        end
    end

    assign o_busy     = r_busy;
    assign o_done     = r_done;
    assign o_quotient = r_q;
endmodule

FILE: rtl/multichannel_decision_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multichannel decision filter
// Per-channel sliding windows with trimmed mean, mode, median, smooth-hold,
// max and min decisions.
// ----------------------------------------------------------------------------
//  Channel   Dir  Payload                                   Handshake
//  i_in      in   sample_value, channel, filter_mode        valid / ready
//  o_out     out  decided_value                             valid / ready
//  i_cfg_*   in   smooth_threshold (16 bits)                write enable
//
// One transaction at a time. A write step comes first, then a window scan;
// trimmed mean and smooth-hold then pass through the reciprocal divider
// (smooth-hold also through a multiply and a compare step); mode and median
// run a pairwise pass of WINDOW_LEN*(WINDOW_LEN+1) reads through the single
// window RAM port instead of the scan. A done step ends each transaction.
// The result sits in an output register, so the next transaction is accepted
// while it waits; the result after it holds in the done step until the register
// is taken. Reset is synchronous and clears every window to zero at once through
// per-entry valid bits.
// ----------------------------------------------------------------------------
module multichannel_decision_filter (
    input  logic             i_clk,
    input  logic             i_rst_n,
    mdf_in_if.sink           i_in,
    mdf_out_if.source        o_out,
    input  logic             i_cfg_wr_en,
    input  logic [15:0]      i_cfg_wr_data
);
    typedef enum logic [3:0] {
        S_IDLE, S_WRITE, S_SCAN, S_NEST, S_DIV, S_SMUL, S_SCMP, S_DONE
    } t_state;

    localparam int N      = mdf_pkg::WINDOW_LEN;
    localparam int SUM_W  = mdf_pkg::SUM_W;
    localparam int ADDR_W = mdf_pkg::ADDR_W;
    localparam int PTR_W  = mdf_pkg::PTR_W;
    localparam int SLOT_W = mdf_pkg::SLOT_W;
    localparam int CNT_W  = mdf_pkg::CNT_W;
    localparam int LIM_W  = mdf_pkg::LIM_W;

    t_state                    r_state;
    logic signed [31:0]        r_sample;
    logic [1:0]                r_ch;
    logic [2:0]                r_mode;
    logic [PTR_W-1:0]          r_wptr [mdf_pkg::CHANNELS];
    logic [mdf_pkg::DEPTH-1:0] r_vbits;
    logic [15:0]               r_thr;
    logic signed [31:0]        r_held;
    logic signed [SUM_W-1:0]   r_sum;
    logic signed [31:0]        r_mx, r_mn;
    logic                      r_issue;
    logic [PTR_W-1:0]          r_i;
    logic [SLOT_W-1:0]         r_s;
    logic                      r_dv;
    logic [PTR_W-1:0]          r_di;
    logic [SLOT_W-1:0]         r_ds;
    logic                      r_rvld;
    logic signed [31:0]        r_wi;
    logic [CNT_W-1:0]          r_ceq, r_clt, r_cle, r_best;
    logic                      r_found;
    logic                      r_neg;
    logic signed [31:0]        r_res;
    logic signed [31:0]        r_mean;
    logic signed [LIM_W-1:0]   r_lim;
    logic                      r_oval;
    logic signed [31:0]        r_odata;

    logic [ADDR_W-1:0]         w_base, w_waddr, w_raddr;
    logic [PTR_W-1:0]          w_ridx;
    logic                      w_re;
    logic [31:0]               w_rdata;
    logic signed [31:0]        w_d;
    logic signed [SUM_W-1:0]   n_sum, w_num, w_mag;
    logic signed [31:0]        n_mx, n_mn;
    logic [PTR_W-1:0]          w_j;
    logic [CNT_W-1:0]          n_ceq, n_clt, n_cle;
    logic                      w_div_start;
    logic                      w_div_busy, w_div_done;
    logic [SUM_W-1:0]          w_quot;
    logic signed [SUM_W-1:0]   w_qs;
    logic signed [LIM_W-1:0]   w_up, w_dn;
    logic                      w_upd;

    // Window addressing: base of the channel plus the slot.
    assign w_base  = ADDR_W'(ADDR_W'(r_ch) * ADDR_W'(N));
    assign w_waddr = w_base + ADDR_W'(r_wptr[r_ch]);
    assign w_ridx  = (r_state == S_NEST) ? ((r_s == '0) ? r_i : PTR_W'(r_s - 1'b1))
                                         : PTR_W'(r_s);
    assign w_raddr = w_base + ADDR_W'(w_ridx);
    assign w_re    = r_issue && ((r_state == S_SCAN) || (r_state == S_NEST));

    mdf_ram #(.WIDTH(32), .DEPTH(mdf_pkg::DEPTH)) u_ram (
        .i_clk   (i_clk),
        .i_we    (r_state == S_WRITE),
        .i_waddr (w_waddr),
        .i_wdata (r_sample),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // An entry never written since reset reads as zero.
    assign w_d = r_rvld ? $signed(w_rdata) : 32'sd0;

    // Scan accumulation: sum, maximum and minimum.
    always_comb begin
        if (r_ds == '0) begin
            n_sum = SUM_W'(w_d);
            n_mx  = w_d;
            n_mn  = w_d;
        end else begin
            n_sum = r_sum + SUM_W'(w_d);
            n_mx  = (w_d > r_mx) ? w_d : r_mx;
            n_mn  = (w_d < r_mn) ? w_d : r_mn;
        end
    end

    // Pairwise counts against the current reference entry.
    assign w_j   = PTR_W'(r_ds - 1'b1);
    assign n_ceq = r_ceq + CNT_W'((w_d == r_wi) && (w_j >= r_di));
    assign n_clt = r_clt + CNT_W'(w_d < r_wi);
    assign n_cle = r_cle + CNT_W'(w_d <= r_wi);

    // Divider operands: trimmed numerator or plain sum, as a magnitude.
    assign w_num       = (r_mode == mdf_pkg::MODE_TRIM)
                       ? (n_sum - SUM_W'(n_mx) - SUM_W'(n_mn)) : n_sum;
    assign w_mag       = w_num[SUM_W-1] ? -w_num : w_num;
    assign w_div_start = (r_state == S_SCAN) && r_dv && (r_ds == SLOT_W'(N - 1))
                       && ((r_mode == mdf_pkg::MODE_TRIM) || (r_mode == mdf_pkg::MODE_SMOOTH));

    mdf_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_trim     (r_mode == mdf_pkg::MODE_TRIM),
        .i_dividend (w_mag),
        .o_busy     (w_div_busy),
        .o_done     (w_div_done),
        .o_quotient (w_quot)
    );

    assign w_qs = r_neg ? -$signed(w_quot) : $signed(w_quot);

    // Smooth-hold spread test against the registered limit.
    assign w_up  = LIM_W'(LIM_W'(r_mx) - LIM_W'(r_mean)) <<< 16;
    assign w_dn  = LIM_W'(LIM_W'(r_mean) - LIM_W'(r_mn)) <<< 16;
    assign w_upd = (r_mean > 32'sd0) && (w_up < r_lim) && (w_dn < r_lim);

    assign i_in.ready          = (r_state == S_IDLE);
    assign o_out.valid         = r_oval;
    assign o_out.decided_value = r_odata;

    // Sequencer, window state and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_vbits <= '0;
            for (int c = 0; c < mdf_pkg::CHANNELS; c++) begin
                r_wptr[c] <= '0;
            end
            r_thr   <= mdf_pkg::THRESH_RESET;
            r_held  <= '0;
            r_issue <= 1'b0;
            r_dv    <= 1'b0;
            r_oval  <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_thr <= i_cfg_wr_data;
            end
            r_dv   <= w_re;
            r_di   <= r_i;
            r_ds   <= r_s;
            r_rvld <= r_vbits[w_raddr];
            if (r_oval && o_out.ready && (r_state != S_DONE)) begin
                r_oval <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_sample <= i_in.sample_value;
                        r_ch     <= i_in.channel;
                        r_mode   <= i_in.filter_mode;
                        if (int'(i_in.channel) >= mdf_pkg::CHANNELS) begin
                            r_res   <= '0;
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_WRITE;
                        end
                    end
                end
                S_WRITE: begin
                    r_vbits[w_waddr] <= 1'b1;
                    r_wptr[r_ch]     <= (r_wptr[r_ch] == PTR_W'(N - 1))
                                      ? '0 : r_wptr[r_ch] + 1'b1;
                    r_i     <= '0;
                    r_s     <= '0;
                    r_best  <= '0;
                    r_found <= 1'b0;
                    if ((r_mode == mdf_pkg::MODE_MODE) || (r_mode == mdf_pkg::MODE_MEDIAN)) begin
                        r_issue <= 1'b1;
                        r_state <= S_NEST;
                    end else if (r_mode <= mdf_pkg::MODE_MIN) begin
                        r_issue <= 1'b1;
                        r_state <= S_SCAN;
                    end else begin
                        r_res   <= '0;
                        r_state <= S_DONE;
                    end
                end
                S_SCAN: begin
                    if (r_issue) begin
                        if (r_s == SLOT_W'(N - 1)) begin
                            r_issue <= 1'b0;
                        end else begin
                            r_s <= r_s + 1'b1;
                        end
                    end
                    if (r_dv) begin
                        r_sum <= n_sum;
                        r_mx  <= n_mx;
                        r_mn  <= n_mn;
                        if (r_ds == SLOT_W'(N - 1)) begin
                            r_neg <= w_num[SUM_W-1];
                            if (r_mode == mdf_pkg::MODE_MAX) begin
                                r_res   <= n_mx;
                                r_state <= S_DONE;
                            end else if (r_mode == mdf_pkg::MODE_MIN) begin
                                r_res   <= n_mn;
                                r_state <= S_DONE;
                            end else begin
                                r_state <= S_DIV;
                            end
                        end
                    end
                end
                S_NEST: begin
                    if (r_issue) begin
                        if (r_s == SLOT_W'(N)) begin
                            r_s <= '0;
                            if (r_i == PTR_W'(N - 1)) begin
                                r_issue <= 1'b0;
                            end else begin
                                r_i <= r_i + 1'b1;
                            end
                        end else begin
                            r_s <= r_s + 1'b1;
                        end
                    end
                    if (r_dv) begin
                        if (r_ds == '0) begin
                            r_wi  <= w_d;
                            r_ceq <= '0;
                            r_clt <= '0;
                            r_cle <= '0;
                        end else begin
                            r_ceq <= n_ceq;
                            r_clt <= n_clt;
                            r_cle <= n_cle;
                            if (r_ds == SLOT_W'(N)) begin
                                if (r_mode == mdf_pkg::MODE_MODE) begin
                                    if (n_ceq > r_best) begin
                                        r_best <= n_ceq;
                                        r_res  <= r_wi;
                                    end
                                end else if (!r_found && (n_clt <= CNT_W'(N / 2))
                                             && (n_cle > CNT_W'(N / 2))) begin
                                    r_found <= 1'b1;
                                    r_res   <= r_wi;
                                end
                                if (r_di == PTR_W'(N - 1)) begin
                                    r_state <= S_DONE;
                                end
                            end
                        end
                    end
                end
                S_DIV: begin
                    if (w_div_done) begin
                        if (r_mode == mdf_pkg::MODE_TRIM) begin
                            r_res   <= w_qs[31:0];
                            r_state <= S_DONE;
                        end else begin
                            r_mean  <= w_qs[31:0];
                            r_state <= S_SMUL;
                        end
                    end
                end
                S_SMUL: begin
                    r_lim   <= LIM_W'($signed({1'b0, r_thr})) * LIM_W'(r_mean);
                    r_state <= S_SCMP;
                end
                S_SCMP: begin
                    if (w_upd) begin
                        r_held <= r_mean;
                        r_res  <= r_mean;
                    end else begin
                        r_res  <= r_held;
                    end
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (!r_oval || o_out.ready) begin
                        r_oval  <= 1'b1;
                        r_odata <= r_res;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // An accepted transaction always leaves idle for the write or the result.
    a_accept_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> ((r_state == S_WRITE) || (r_state == S_DONE)))
        else $error("accepted transaction did not start");

    // The divider runs only while the sequencer waits on it.
    a_div_owned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_busy |-> (r_state == S_DIV))
        else $error("divider busy outside the divide step");

    // The held smooth value changes only in the smooth-hold compare step.
    a_held_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_held != $past(r_held)) |-> ($past(r_state) == S_SCMP))
        else $error("held value changed outside smooth-hold");
endmodule

FILE: tb/multichannel_decision_filter_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Decision filter testbench
// Drives random and directed samples into the multichannel decision filter,
// predicts each decision from a private copy of the windows, the write
// pointers, the held smooth value and the threshold, and checks every result
// in order. Both sides insert random gaps, and the threshold is rewritten
// between phases while the block is idle.
// ----------------------------------------------------------------------------

// Scoreboard: holds the predicted filter state and the queue of pending decisions.
class decision_board;
    int                 nch;
    int                 nwin;
    logic signed [31:0] windows [16][32];
    int                 wr_ptr [16];
    logic signed [31:0] held_value;
    logic [15:0]        threshold;
    logic signed [31:0] pending_decisions [$];
    int                 mismatches;

    function void init(int channels, int window_len);
        nch = channels;
        nwin = window_len;
        for (int c = 0; c < 16; c++) begin
            wr_ptr[c] = 0;
            for (int i = 0; i < 32; i++) windows[c][i] = '0;
        end
        held_value = '0;
        threshold = mdf_pkg::THRESH_RESET;
        mismatches = 0;
        pending_decisions.delete();
    endfunction

    // Store the sample and predict the decision for this transaction.
    function void note_sample(logic signed [31:0] sample, logic [1:0] ch, logic [2:0] md);
        logic signed [31:0] w [32];
        logic signed [31:0] mx, mn, res, tmp;
        longint sum, mean, lim;
        int best, at, cnt, k;
        res = '0;
        if (ch >= nch) begin
            pending_decisions.push_back(res);
            return;
        end
        windows[ch][wr_ptr[ch]] = sample;
        wr_ptr[ch] = (wr_ptr[ch] + 1) % nwin;
        for (int i = 0; i < nwin; i++) w[i] = windows[ch][i];
        mx = w[0];
        mn = w[0];
        sum = 0;
        for (int i = 0; i < nwin; i++) begin
            sum += longint'(w[i]);
            if (w[i] > mx) mx = w[i];
            if (w[i] < mn) mn = w[i];
        end
        case (md)
            mdf_pkg::MODE_TRIM: res = 32'((sum - longint'(mx) - longint'(mn)) / (nwin - 2));
            mdf_pkg::MODE_MODE: begin
                best = 0;
                at = 0;
                for (int i = 0; i < nwin; i++) begin
                    cnt = 0;
                    for (int j = i; j < nwin; j++) if (w[i] == w[j]) cnt++;
                    if (cnt > best) begin
                        best = cnt;
                        at = i;
                    end
                end
                res = w[at];
            end
            mdf_pkg::MODE_MEDIAN: begin
                // Selection sort of a copy, then take the middle entry.
                for (int i = 0; i + 1 < nwin; i++) begin
                    k = i;
                    for (int j = i + 1; j < nwin; j++) if (w[k] > w[j]) k = j;
                    tmp = w[i];
                    w[i] = w[k];
                    w[k] = tmp;
                end
                res = w[nwin / 2];
            end
            mdf_pkg::MODE_SMOOTH: begin
                mean = sum / nwin;
                lim = longint'(threshold) * mean;
                if (mean > 0 && (longint'(mx) - mean) * 65536 < lim
                        && (mean - longint'(mn)) * 65536 < lim)
                    held_value = 32'(mean);
                res = held_value;
            end
            mdf_pkg::MODE_MAX: res = mx;
            mdf_pkg::MODE_MIN: res = mn;
            default: res = '0;
        endcase
        pending_decisions.push_back(res);
    endfunction

    // Compare one delivered decision with the oldest prediction.
    function void check_decision(logic signed [31:0] got);
        logic signed [31:0] exp_val;
        if (pending_decisions.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("Unexpected decision %0d", got);
            return;
        end
        exp_val = pending_decisions.pop_front();
        if (got !== exp_val) begin
            mismatches++;
            if (mismatches <= 10)
                $display("Decision mismatch: expected %0d, actual %0d", exp_val, got);
        end
    endfunction
endclass

module multichannel_decision_filter_tb;

    localparam longint CYCLE_LIMIT = 2000000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_wr_en;
    logic [15:0] i_cfg_wr_data;
    longint      cycles;

    mdf_in_if  in_ch ();
    mdf_out_if out_ch ();

    decision_board board;

    multichannel_decision_filter uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (in_ch.sink),
        .o_out        (out_ch.source),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data)
    );

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Random gap length: mostly short, sometimes long.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 120);
    endfunction

    // Send one sample transaction and wait until it is accepted.
    task automatic send_sample(logic signed [31:0] sample, logic [1:0] ch, logic [2:0] md);
        int idle;
        idle = gap_len();
        if (idle > 0) begin
            in_ch.valid <= 1'b0;
            repeat (idle) @(posedge i_clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.sample_value <= sample;
        in_ch.channel      <= ch;
        in_ch.filter_mode  <= md;
        do @(posedge i_clk); while (!in_ch.ready);
        board.note_sample(sample, ch, md);
    endtask

    // Wait for every pending decision, then let the block settle.
    task automatic drain();
        in_ch.valid <= 1'b0;
        while (board.pending_decisions.size() != 0) @(posedge i_clk);
        repeat (5) @(posedge i_clk);
    endtask

    // Write the threshold register while idle.
    task automatic write_threshold(logic [15:0] value);
        drain();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        board.threshold = value;
    endtask

    // Random sample: mostly near a base level so windows repeat and smooth-hold fires.
    function automatic logic signed [31:0] rand_sample(logic signed [31:0] base);
        int r;
        r = $urandom_range(0, 9);
        if (r < 3) return base;
        if (r < 7) return base + $signed($urandom_range(0, 4000)) - 2000;
        if (r < 8) return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
        return $urandom;
    endfunction

    task automatic random_phase(int count);
        logic signed [31:0] base;
        base = $urandom_range(1, 32'h00ffffff);
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 30) == 0) base = $urandom;
            send_sample(rand_sample(base), 2'($urandom_range(0, 3)),
                        3'($urandom_range(0, 7)));
        end
    endtask

    // Output side: random stalls, check each accepted decision.
    initial begin
        int idle;
        out_ch.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            idle = ($urandom_range(0, 3) == 0) ? 0 : gap_len();
            if (idle > 0) begin
                out_ch.ready <= 1'b0;
                repeat (idle) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!out_ch.valid);
            board.check_decision(out_ch.decided_value);
        end
    end

    // Cycle limit.
    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // Main stimulus.
    initial begin
        board = new();
        board.init(mdf_pkg::CHANNELS, mdf_pkg::WINDOW_LEN);
        i_rst_n            <= 1'b0;
        i_cfg_wr_en        <= 1'b0;
        i_cfg_wr_data      <= '0;
        in_ch.valid        <= 1'b0;
        in_ch.sample_value <= '0;
        in_ch.channel      <= '0;
        in_ch.filter_mode  <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: cleared windows, every mode, extremes, ties in mode.
        for (int m = 0; m < 8; m++) send_sample('0, 2'(m % 4), 3'(m));
        send_sample(32'sh7fffffff, 2'd0, mdf_pkg::MODE_MAX);
        send_sample(32'sh80000000, 2'd0, mdf_pkg::MODE_MIN);
        send_sample(32'sh7fffffff, 2'd0, mdf_pkg::MODE_TRIM);
        send_sample(32'sh80000000, 2'd0, mdf_pkg::MODE_MEDIAN);
        send_sample(32'sh00010000, 2'd1, mdf_pkg::MODE_MODE);
        send_sample(32'sh00010000, 2'd1, mdf_pkg::MODE_MODE);
        for (int i = 0; i < 8; i++) send_sample(32'sh00050000, 2'd2, mdf_pkg::MODE_SMOOTH);
        send_sample(-32'sh00050000, 2'd3, mdf_pkg::MODE_SMOOTH);
        send_sample(32'shffffffff, 2'd3, 3'd7);

        // Hold-off: wait for all results before sending more.
        drain();
        random_phase(300);
        write_threshold(16'd0);
        random_phase(200);
        write_threshold(16'hffff);
        random_phase(300);
        write_threshold(16'd1);
        random_phase(150);
        write_threshold(16'd20000);
        random_phase(250);

        drain();
        repeat (200) @(posedge i_clk);
        if (board.mismatches == 0 && board.pending_decisions.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule

FILE: files.f
rtl/mdf_pkg.sv
rtl/mdf_if.sv
rtl/mdf_ram.sv
rtl/mdf_div.sv
rtl/multichannel_decision_filter.sv
tb/multichannel_decision_filter_tb.sv
